>>> rtl/qaud_pkg.sv
// Shared constants, kind codes, the hex digit decoder and the '+' mapping of the query argument decoder.
package qaud_pkg;

	localparam int KEY_BYTES_DEF = 32;

	localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
	localparam logic [7:0] CH_EQ      = 8'h3d;  // '='
	localparam logic [7:0] CH_PCT     = 8'h25;  // '%'
	localparam logic [7:0] CH_PLUS    = 8'h2b;  // '+'
	localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '

	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_PAIR  = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

	// '+' reads as a space, everything else as itself
	function automatic logic [7:0] plain_map(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

>>> rtl/qaud_key_ram.sv
// Key buffer: one write port, one read port with registered read data.
module qaud_key_ram #(
	parameter int KEY_BYTES = qaud_pkg::KEY_BYTES_DEF,
	parameter int IDX_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [7:0]       rd_data
);
	import qaud_pkg::*;

	logic [7:0] mem [KEY_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/query_argument_url_decoder.sv
// Top level of the URL query argument decoder: sequencer, key buffer and output register.
//
// Use: raw query bytes enter on the s_ stream, one byte per transaction, with
// s_tlast set on a closing transaction that carries no byte. Decoded key
// bytes (kind 0), value bytes (kind 1), pair-complete markers (kind 2, with
// the key-truncated flag) and the done marker (kind 3) leave on the m_ stream;
// m_tlast flags the final result caused by one input transaction. Many input
// bytes cause no result at all.
// Timing: an input transaction is registered on acceptance and decoded in the
// decode state, which waits while the result slot is full. On '=' the buffered
// key is replayed from the key RAM at one byte per cycle while the m_ side takes
// them, after a read start-up state; a cut-short escape adds a flush state per
// flushed byte, and a pair close or end one state per marker.
// s_tready is high only while the sequencer is idle.
// Reset clears all control state; the key RAM is not cleared and is only read
// below the fill count. A stalled m_ side holds the output register; the
// sequencer waits and takes no further input until the result slot frees,
// but an item can be accepted while a finished result still waits.
module query_argument_url_decoder #(
	parameter int KEY_BYTES = qaud_pkg::KEY_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] query_byte
	input  logic       s_tlast,   // is_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [1:0] kind, [2] key_truncated
	output logic       m_tlast    // last
);
	import qaud_pkg::*;

	localparam int LEN_W = $clog2(KEY_BYTES + 1);
	localparam int IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	typedef enum logic [7:0] {
		ST_IDLE       = 8'b0000_0001,
		ST_DECODE     = 8'b0000_0010,
		ST_FLUSH_PCT  = 8'b0000_0100,
		ST_FLUSH_HELD = 8'b0000_1000,
		ST_REPLAY_RD  = 8'b0001_0000,
		ST_REPLAY     = 8'b0010_0000,
		ST_CLOSE      = 8'b0100_0000,
		ST_DONE       = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		kind_t      kind;
		logic       trunc;
		logic       last;
	} beat_t;

	state_t           state_q, state_d;
	logic             in_value_q, in_value_d;
	logic [LEN_W-1:0] key_len_q, key_len_d;
	logic [1:0]       esc_q, esc_d;
	logic [7:0]       held_q, held_d;
	logic             ovf_q, ovf_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0]       byte_q;
	logic             end_q;

	// output register
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	kind_t            out_kind_q;
	logic             out_trunc_q;
	logic             out_last_q;

	beat_t            beat;
	logic             out_free;
	logic             accept;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       rd_data;

	logic [4:0]       hi_dig, lo_dig;
	logic [7:0]       esc_val;
	logic [7:0]       dlv_byte;
	logic             dlv_last;
	logic             dlv_en;
	logic             replay_go;
	logic             replay_end;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// strtol-like escape value
	assign hi_dig  = hex_nibble(held_q);
	assign lo_dig  = hex_nibble(byte_q);
	assign esc_val = !hi_dig[4] ? 8'd0 :
	                 !lo_dig[4] ? {4'd0, hi_dig[3:0]} : {hi_dig[3:0], lo_dig[3:0]};

	assign replay_end = ((LEN_W'(idx_q) + LEN_W'(1)) == key_len_q);
	assign rd_addr    = (state_q == ST_REPLAY && out_free) ? (idx_q + IDX_W'(1)) : idx_q;

	always_comb begin
		state_d    = state_q;
		in_value_d = in_value_q;
		key_len_d  = key_len_q;
		esc_d      = esc_q;
		held_d     = held_q;
		ovf_d      = ovf_q;
		idx_d      = idx_q;
		beat       = '{valid: 1'b0, data: 8'd0, kind: KIND_KEY, trunc: 1'b0, last: 1'b0};
		wr_en      = 1'b0;
		wr_addr    = key_len_q[IDX_W-1:0];
		wr_data    = 8'd0;
		dlv_en     = 1'b0;
		dlv_byte   = 8'd0;
		dlv_last   = 1'b0;
		replay_go  = 1'b0;

		if (out_free) begin
			case (state_q)
				ST_DECODE: begin
					state_d = ST_IDLE;
					if (end_q) begin
						state_d = in_value_q ? ((esc_q != 2'd0) ? ST_FLUSH_PCT : ST_CLOSE)
						                     : ST_DONE;
					end else if (byte_q == CH_AMP) begin
						if (in_value_q) begin
							state_d = (esc_q != 2'd0) ? ST_FLUSH_PCT : ST_CLOSE;
						end else begin
							in_value_d = 1'b0;
							key_len_d  = '0;
							ovf_d      = 1'b0;
							esc_d      = 2'd0;
							held_d     = 8'd0;
						end
					end else if (byte_q == CH_EQ && !in_value_q) begin
						if (esc_q != 2'd0) begin
							state_d = ST_FLUSH_PCT;
						end else begin
							replay_go = 1'b1;
						end
					end else if (esc_q == 2'd1) begin
						held_d = byte_q;
						esc_d  = 2'd2;
					end else if (esc_q == 2'd2) begin
						esc_d    = 2'd0;
						held_d   = 8'd0;
						dlv_en   = 1'b1;
						dlv_byte = esc_val;
						dlv_last = 1'b1;
					end else if (byte_q == CH_PCT) begin
						esc_d = 2'd1;
					end else begin
						dlv_en   = 1'b1;
						dlv_byte = plain_map(byte_q);
						dlv_last = 1'b1;
					end
				end
				ST_FLUSH_PCT: begin
					dlv_en   = 1'b1;
					dlv_byte = CH_PCT;
				end
				ST_FLUSH_HELD: begin
					dlv_en   = 1'b1;
					dlv_byte = plain_map(held_q);
				end
				ST_REPLAY_RD: begin
					state_d = ST_REPLAY;
				end
				ST_REPLAY: begin
					beat = '{valid: 1'b1, data: rd_data, kind: KIND_KEY, trunc: 1'b0,
					         last: replay_end};
					if (replay_end) begin
						in_value_d = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
				ST_CLOSE: begin
					beat = '{valid: 1'b1, data: 8'd0, kind: KIND_PAIR, trunc: ovf_q,
					         last: !end_q};
					in_value_d = 1'b0;
					key_len_d  = '0;
					ovf_d      = 1'b0;
					esc_d      = 2'd0;
					held_d     = 8'd0;
					state_d    = end_q ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					beat = '{valid: 1'b1, data: 8'd0, kind: KIND_DONE, trunc: 1'b0,
					         last: 1'b1};
					in_value_d = 1'b0;
					key_len_d  = '0;
					ovf_d      = 1'b0;
					esc_d      = 2'd0;
					held_d     = 8'd0;
					state_d    = ST_IDLE;
				end
				default: begin
				end
			endcase

			// one decoded byte: value byte out, or into the key buffer (overflow flag once full); zero dropped
			if (dlv_en && dlv_byte != 8'd0) begin
				if (in_value_q) begin
					beat = '{valid: 1'b1, data: dlv_byte, kind: KIND_VALUE, trunc: 1'b0,
					         last: dlv_last};
				end else if (key_len_q < LEN_W'(KEY_BYTES)) begin
					wr_en     = 1'b1;
					wr_data   = dlv_byte;
					key_len_d = key_len_q + LEN_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end

			// end of an escape flush
			if ((state_q == ST_FLUSH_PCT && esc_q != 2'd2) || state_q == ST_FLUSH_HELD) begin
				esc_d  = 2'd0;
				held_d = 8'd0;
				if (in_value_q) begin
					state_d = ST_CLOSE;
				end else begin
					replay_go = 1'b1;
				end
			end else if (state_q == ST_FLUSH_PCT) begin
				state_d = ST_FLUSH_HELD;
			end

			// '=' ends the key: replay what is buffered
			if (replay_go) begin
				idx_d = '0;
				if (key_len_d == '0) begin
					in_value_d = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_REPLAY_RD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_value_q  <= 1'b0;
			key_len_q   <= '0;
			esc_q       <= 2'd0;
			held_q      <= 8'd0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= accept ? ST_DECODE : state_d;
			in_value_q <= in_value_d;
			key_len_q  <= key_len_d;
			esc_q      <= esc_d;
			held_q     <= held_d;
			ovf_q      <= ovf_d;
			idx_q      <= idx_d;
			if (beat.valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= s_tdata;
			end_q  <= s_tlast;
		end
		if (beat.valid) begin
			out_data_q  <= beat.data;
			out_kind_q  <= beat.kind;
			out_trunc_q <= beat.trunc;
			out_last_q  <= beat.last;
		end
	end

	qaud_key_ram #(
		.KEY_BYTES (KEY_BYTES),
		.IDX_W     (IDX_W)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_trunc_q, out_kind_q};
	assign m_tlast  = out_last_q;

endmodule

>>> tb/sv/query_decoder_checker.sv
// Checker for the query argument decoder: predicts decoded results and compares each one.
module query_decoder_checker #(
	parameter int KEY_BYTES = qaud_pkg::KEY_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] query_byte
	input  logic       s_tlast,   // is_end
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic [2:0] m_tuser,   // [1:0] kind, [2] key_truncated
	input  logic       m_tlast,
	input  logic       run_over,
	output int         mismatches,
	output int         pending,
	output int         checked
);
	import qaud_pkg::*;

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_AFTER_PCT,
		ESC_AFTER_DIGIT
	} esc_t;

	typedef struct {
		logic [7:0] data;
		kind_t      kind;
		logic       truncated;
		logic       last;
	} decoded_t;

	decoded_t   decoded_q[$];
	logic [7:0] key_store[KEY_BYTES];
	int         key_len = 0;
	logic       in_value = 1'b0;
	logic       key_cut = 1'b0;
	esc_t       esc = ESC_IDLE;
	logic [7:0] held_digit = 8'h00;
	logic       closed = 1'b0;
	int         error_count = 0;
	int         pending_n = 0;
	int         checked_n = 0;

	assign mismatches = error_count;
	assign pending    = pending_n;
	assign checked    = checked_n;

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] ERROR: %s", $time, what);
	endtask

	// -1 for a non-hex character
	function automatic int digit_value(input logic [7:0] c);
		int v;
		v = c;
		if (c >= "0" && c <= "9")
			return v - 48;
		if (c >= "a" && c <= "f")
			return v - 87;
		if (c >= "A" && c <= "F")
			return v - 55;
		return -1;
	endfunction

	task automatic push_result(input logic [7:0] data, input kind_t kind, input logic cut);
		decoded_t r;
		r.data      = data;
		r.kind      = kind;
		r.truncated = cut;
		r.last      = 1'b0;
		decoded_q.push_back(r);
	endtask

	task automatic deliver(input logic [7:0] b);
		if (b == 8'h00)
			return;
		if (in_value) begin
			push_result(b, KIND_VALUE, 1'b0);
		end else if (key_len < KEY_BYTES) begin
			key_store[key_len] = b;
			key_len++;
		end else begin
			key_cut = 1'b1;
		end
	endtask

	task automatic literal(input logic [7:0] c);
		deliver((c == CH_PLUS) ? CH_SPACE : c);
	endtask

	// escape interrupted by a delimiter: its bytes are delivered as literal characters
	task automatic flush_escape();
		if (esc != ESC_IDLE) begin
			literal(CH_PCT);
			if (esc == ESC_AFTER_DIGIT)
				literal(held_digit);
		end
		esc        = ESC_IDLE;
		held_digit = 8'h00;
	endtask

	task automatic clear_pair();
		in_value   = 1'b0;
		key_len    = 0;
		key_cut    = 1'b0;
		esc        = ESC_IDLE;
		held_digit = 8'h00;
	endtask

	task automatic decode_query_byte(input logic [7:0] c, input logic is_end);
		int         first;
		int         hi;
		int         lo;
		logic [7:0] v;
		decoded_t   tail;
		first = decoded_q.size();
		if (is_end) begin
			if (in_value) begin
				flush_escape();
				push_result(8'h00, KIND_PAIR, key_cut);
			end
			push_result(8'h00, KIND_DONE, 1'b0);
			clear_pair();
		end else if (c == CH_AMP) begin
			if (in_value) begin
				flush_escape();
				push_result(8'h00, KIND_PAIR, key_cut);
			end
			clear_pair();
		end else if (c == CH_EQ && !in_value) begin
			flush_escape();
			for (int i = 0; i < key_len; i++)
				push_result(key_store[i], KIND_KEY, 1'b0);
			in_value = 1'b1;
		end else if (esc == ESC_AFTER_PCT) begin
			held_digit = c;
			esc        = ESC_AFTER_DIGIT;
		end else if (esc == ESC_AFTER_DIGIT) begin
			hi = digit_value(held_digit);
			lo = digit_value(c);
			if (hi < 0)
				v = 8'h00;
			else if (lo < 0)
				v = hi[7:0];
			else
				v = 8'(hi * 16 + lo);
			esc        = ESC_IDLE;
			held_digit = 8'h00;
			deliver(v);
		end else if (c == CH_PCT) begin
			esc = ESC_AFTER_PCT;
		end else begin
			literal(c);
		end
		if (decoded_q.size() > first) begin
			tail      = decoded_q.pop_back();
			tail.last = 1'b1;
			decoded_q.push_back(tail);
		end
	endtask

	task automatic check_result();
		decoded_t e;
		if (decoded_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result data %h user %h last %b",
				m_tdata, m_tuser, m_tlast));
			return;
		end
		e = decoded_q.pop_front();
		checked_n++;
		if (m_tdata !== e.data || m_tuser[1:0] !== e.kind || m_tuser[2] !== e.truncated ||
				m_tlast !== e.last)
			report_mismatch($sformatf(
				"got data %h kind %0d cut %b last %b, want data %h kind %0d cut %b last %b",
				m_tdata, m_tuser[1:0], m_tuser[2], m_tlast,
				e.data, e.kind, e.truncated, e.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_pair();
			decoded_q.delete();
			pending_n <= 0;
		end else begin
			if (s_tvalid && s_tready)
				decode_query_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_result();
			if (run_over && !closed) begin
				closed = 1'b1;
				if (decoded_q.size() != 0)
					report_mismatch($sformatf("%0d expected results never arrived",
						decoded_q.size()));
			end
			pending_n <= decoded_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the query argument decoder testbench: clock, reset, query stimulus and verdict.
module testbench;
	import qaud_pkg::*;

	localparam int QUERY_ITEMS = 320;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] query_byte
	logic       s_tlast = 1'b0;    // is_end
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic [2:0] m_tuser;           // [1:0] kind, [2] key_truncated
	logic       m_tlast;
	logic       run_over = 1'b0;

	int mismatches;
	int pending;
	int checked;
	int sent = 0;
	int cycle = 0;

	query_argument_url_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// The checker sees both streams exactly as the block does and owns all prediction.
	query_decoder_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.run_over   (run_over),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycle <= cycle + 1;

	// Result side: stalls on about 6 percent of cycles, none at all in a window mid-run
	// so that back-to-back replays get exercised at full rate.
	always @(posedge clk) begin
		if (cycle >= 250 && cycle < 650)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= 6);
	end

	// Backstop: far beyond the slowest correct run (every item replaying a full key,
	// each result meeting a stall, plus the drain pauses).
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// One query transaction. A gap, if any, is taken before raising tvalid, so tvalid
	// is only ever written once in a time step.
	task automatic send_item(input logic [7:0] b, input logic is_end);
		int gap;
		gap = 0;
		if (sent < 200 || sent >= 280)
			while ($urandom_range(99) < 6)
				gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= is_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	// Hold the sender off until the checker has nothing outstanding. The pending
	// count is registered, hence the first wait.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Query character mix: heavy on hex digits and escapes so '%' sequences of
	// every shape turn up, with some raw bytes across the whole 8-bit range.
	function automatic logic [7:0] pick_char(input logic in_value);
		string hex_set;
		int    r;
		hex_set = "0123456789abcdefABCDEF";
		r = $urandom_range(99);
		if (r < 30)
			return hex_set[$urandom_range(21)];
		if (r < 42)
			return CH_PCT;
		if (r < 48)
			return CH_PLUS;
		if (r < 52 && in_value)
			return CH_EQ;
		if (r < 62)
			return 8'($urandom_range(255));
		if (r < 65)
			return 8'h00;
		return 8'("g" + $urandom_range(19));
	endfunction

	initial begin
		int  key_n;
		int  val_n;
		int  seg;
		bit  paused;
		seg    = 0;
		paused = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed query. Covers: a literal zero byte dropped; a full escape in the
		// key; an invalid first escape digit giving zero (dropped); an escape cut by
		// '='; '+' to space and '=' inside a value; a valid digit with an invalid
		// second; the top byte value; an escaped zero; an escape cut by '&'; a
		// segment with no '='; an escape cut by the end; an end with a nonzero
		// byte; and an end with no pair open.
		send_item(8'h00, 1'b0);
		send_text("%Af%z1%4=");
		send_text("+=%7x");
		send_item(8'hFF, 1'b0);
		send_text("%00%&k&q=%b");
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);

		// Random queries: mostly well-formed key=value segments, with the odd
		// oversized key, missing '=', stray noise byte and early end.
		while (sent < QUERY_ITEMS) begin
			if (!paused && sent >= 160) begin
				paused = 1;
				wait_drained();
			end
			if (seg == 0 || $urandom_range(99) < 5)
				key_n = $urandom_range(KEY_BYTES_DEF + 8, KEY_BYTES_DEF - 2);
			else
				key_n = $urandom_range(6);
			for (int i = 0; i < key_n; i++)
				send_item(pick_char(1'b0), 1'b0);
			if ($urandom_range(99) < 88) begin
				send_item(CH_EQ, 1'b0);
				val_n = $urandom_range(8);
				for (int i = 0; i < val_n; i++)
					send_item(pick_char(1'b1), 1'b0);
			end
			if ($urandom_range(99) < 3)
				send_item(8'($urandom_range(255)), 1'b0);
			if ($urandom_range(99) < 8)
				send_item(8'($urandom_range(255)), 1'b1);
			else
				send_item(CH_AMP, 1'b0);
			seg++;
		end
		send_item(8'($urandom_range(255)), 1'b1);

		// All accepted: let the results drain, then wait out any byte still in the
		// decode stage, then have the checker account for leftovers.
		wait_drained();
		repeat (8) @(posedge clk);
		run_over <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Ran %0d query transactions in %0d segments over %0d cycles.", sent, seg,
			cycle);
		$display("Checked %0d decoded results, including escapes, overflow and stalls.",
			checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
